/* hw/rtl/imu_complementary_tilt_filter_macros.svh */
// Assertion macros for the complementary tilt filter checker.
// Both sample on the rising edge of clk; the first one is gated by rst_n.
`ifndef IMU_COMPLEMENTARY_TILT_FILTER_MACROS_SVH
`define IMU_COMPLEMENTARY_TILT_FILTER_MACROS_SVH

`define ICTF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`define ICTF_ASSERT_NR(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* hw/rtl/ictf_pkg.sv */
// Shared types, constants and arithmetic helpers for the tilt filter.
// No dependencies.
`default_nettype none
package ictf_pkg;

  localparam int unsigned CAL_SAMPLES_DEF = 200;
  localparam int          SQRT_ITERS      = 24;
  localparam int          CORDIC_ITERS    = 17;
  localparam int          MUL_STEPS       = 8;
  localparam int          DIV_ITERS       = 4;

  localparam logic [16:0] ALPHA_RST = 17'd64225;
  localparam logic [16:0] ALPHA_ONE = 17'd65536;
  localparam logic [31:0] SCALE_RST = 32'd327869;

  localparam logic [0:0] REG_ALPHA = 1'b0;
  localparam logic [0:0] REG_SCALE = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE, ST_SQRT, ST_CPRE, ST_CITER, ST_MUL, ST_OUT, ST_DLOAD, ST_DIV, ST_DSTORE
  } ictf_state_t;

  // atan(2^-i) in Q16 degrees
  function automatic logic signed [31:0] atan_q16(input logic [4:0] i);
    logic signed [31:0] v;
    case (i)
      5'd0:  v = 32'sd2949120;
      5'd1:  v = 32'sd1740967;
      5'd2:  v = 32'sd919879;
      5'd3:  v = 32'sd466945;
      5'd4:  v = 32'sd234379;
      5'd5:  v = 32'sd117304;
      5'd6:  v = 32'sd58666;
      5'd7:  v = 32'sd29335;
      5'd8:  v = 32'sd14668;
      5'd9:  v = 32'sd7334;
      5'd10: v = 32'sd3667;
      5'd11: v = 32'sd1833;
      5'd12: v = 32'sd917;
      5'd13: v = 32'sd458;
      5'd14: v = 32'sd229;
      5'd15: v = 32'sd115;
      5'd16: v = 32'sd57;
      default: v = 32'sd0;
    endcase
    return v;
  endfunction

  // right shift rounding half away from zero
  function automatic logic signed [68:0] rnd_shr(input logic signed [68:0] v,
                                                 input int unsigned s);
    logic [68:0] mag;
    logic [68:0] half;
    logic [68:0] r;
    half = 69'(1) << (s - 1);
    mag  = v[68] ? 69'(-v) : 69'(v);
    r    = (mag + half) >> s;
    return v[68] ? -$signed(r) : $signed(r);
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [68:0] v);
    logic signed [31:0] r;
    if (v > 69'sd2147483647)       r = 32'sh7FFFFFFF;
    else if (v < -69'sd2147483648) r = 32'sh80000000;
    else                           r = v[31:0];
    return r;
  endfunction

endpackage
`default_nettype wire

/* hw/rtl/imu_complementary_tilt_filter.sv */
// Complementary pitch/roll/yaw filter for a six-axis IMU, top level.
// Depends on ictf_pkg.
//
// Usage: one input beat per sensor sample on the in_ channel (valid/stall).
// command=1 is a calibration sample: the gyro readings of a good read are
// summed and no result beat follows. After CAL_SAMPLES calibration beats the
// sums become biases (three divisions on the shared multiplier) and all
// angles clear. command=0 fuses the sample and returns one out_ beat with
// pitch, roll and yaw (Q15.16 deg). A good fuse beat passes through the
// bit-serial square root, the shared CORDIC unit (pitch then roll), the
// shared multiplier and the load of the output register; the next beat is
// taken only after that load. A failed read skips these steps and answers
// through ST_OUT with the angles unchanged.
// in_stall is high while an item is in work; one item at a time.
// The result sits in an output register; a stalled receiver holds it there
// while the block may take and finish calibration beats. A new fuse result
// waits in ST_OUT until the register frees up.
// Reset (synchronous, rst_n low) restores the register defaults and clears
// angles, biases, sums and the sample count. Config writes go via cfg_we.
`default_nettype none
module imu_complementary_tilt_filter #(
  parameter int unsigned CAL_SAMPLES = ictf_pkg::CAL_SAMPLES_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [0:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_command,
  input  logic               in_read_ok,
  input  logic signed [15:0] in_accel_x,
  input  logic signed [15:0] in_accel_y,
  input  logic signed [15:0] in_accel_z,
  input  logic signed [15:0] in_rate_x,
  input  logic signed [15:0] in_rate_y,
  input  logic signed [15:0] in_rate_z,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] out_pitch_out,
  output logic signed [31:0] out_roll_out,
  output logic signed [31:0] out_yaw_out
);
  import ictf_pkg::*;

  localparam logic [31:0] CAL_K    = 32'(CAL_SAMPLES);
  localparam logic [9:0]  CAL_CNT  = 10'(CAL_SAMPLES);
  localparam logic [31:0] CAL_HALF = 32'(CAL_SAMPLES / 2);
  // floor((2^32 - 1) / CAL_SAMPLES); the quotient estimate is low by at most one
  localparam logic [31:0] CAL_RECIP = 32'(64'hFFFF_FFFF / 64'(CAL_SAMPLES));

  ictf_state_t state_r, state_nxt;
  logic [4:0]  cnt_r;
  logic [1:0]  sel_r;

  logic [16:0] alpha_r;
  logic [31:0] scale_r;
  logic signed [31:0] pitch_r, roll_r, yaw_r;
  logic signed [23:0] bias_r [3];
  logic signed [23:0] sum_r [3];
  logic [9:0]  count_r;

  logic signed [15:0] ax_r, ay_r, az_r;
  logic signed [15:0] rt_r [3];

  logic [47:0] n_r;
  logic [27:0] rem_r;
  logic [23:0] root_r;

  logic signed [35:0] cx_r, cy_r;
  logic signed [31:0] cz_r;
  logic               czero_r;
  logic signed [31:0] accp_r, accr_r;

  logic signed [68:0] prod_r, bl_r;
  logic signed [34:0] inc_r [3];

  logic [31:0]        dvd_r;
  logic [31:0]        dq_r;
  logic               dneg_r;

  logic               out_valid_r;
  logic signed [31:0] out_pitch_r, out_roll_r, out_yaw_r;

  logic in_acc, out_load;
  logic signed [15:0] in_rate [3];
  logic [9:0] count_inc;
  logic [16:0] a_eff;

  assign in_rate[0] = in_rate_x;
  assign in_rate[1] = in_rate_y;
  assign in_rate[2] = in_rate_z;
  assign count_inc  = count_r + 10'd1;
  assign a_eff      = (alpha_r > ALPHA_ONE) ? ALPHA_ONE : alpha_r;

  // outputs of the sequencer
  always_comb begin
    in_stall = (state_r != ST_IDLE);
    out_load = (state_r == ST_OUT) && (!out_valid_r || !out_stall);
  end
  assign in_acc = in_valid && !in_stall;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_command) state_nxt = (count_inc >= CAL_CNT) ? ST_DLOAD : ST_IDLE;
          else            state_nxt = in_read_ok ? ST_SQRT : ST_OUT;
        end
      end
      ST_SQRT:   if (cnt_r == 5'(SQRT_ITERS - 1)) state_nxt = ST_CPRE;
      ST_CPRE:   state_nxt = ST_CITER;
      ST_CITER: begin
        if (cnt_r == 5'(CORDIC_ITERS - 1)) state_nxt = (sel_r == 2'd0) ? ST_CPRE : ST_MUL;
      end
      ST_MUL:    if (cnt_r == 5'(MUL_STEPS - 1)) state_nxt = ST_OUT;
      ST_OUT:    if (out_load) state_nxt = ST_IDLE;
      ST_DLOAD:  state_nxt = ST_DIV;
      ST_DIV:    if (cnt_r == 5'(DIV_ITERS - 1)) state_nxt = ST_DSTORE;
      ST_DSTORE: state_nxt = (sel_r == 2'd2) ? ST_IDLE : ST_DLOAD;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // square root step
  logic [27:0] sq_t, sq_trial;
  assign sq_t     = {rem_r[25:0], n_r[47:46]};
  assign sq_trial = {2'b00, root_r, 2'b01};

  // CORDIC load with quarter-turn pre-rotation
  logic signed [35:0] cx0, cy0;
  always_comb begin
    if (sel_r == 2'd0) begin
      cy0 = -(36'(ax_r) <<< 14);
      cx0 = $signed({6'b0, root_r, 6'b0});
    end else begin
      cy0 = 36'(ay_r) <<< 14;
      cx0 = 36'(az_r) <<< 14;
    end
  end

  logic signed [35:0] cdx, cdy;
  logic signed [31:0] cz_upd;
  assign cdx    = cx_r >>> cnt_r;
  assign cdy    = cy_r >>> cnt_r;
  assign cz_upd = cy_r[35] ? (cz_r - atan_q16(cnt_r)) : (cz_r + atan_q16(cnt_r));

  // shared multiplier operands
  logic signed [35:0] mul_a;
  logic signed [32:0] mul_b;
  logic signed [24:0] c_sel;
  always_comb begin
    c_sel = 25'sd0;
    mul_a = 36'sd0;
    mul_b = 33'sd0;
    if (state_r == ST_DIV) begin
      // quotient estimate by reciprocal, then estimate times divisor
      case (cnt_r)
        5'd0: begin
          mul_a = 36'(dvd_r);
          mul_b = $signed({1'b0, CAL_RECIP});
        end
        5'd2: begin
          mul_a = 36'(dq_r);
          mul_b = $signed({1'b0, CAL_K});
        end
        default: begin
          mul_a = 36'sd0;
          mul_b = 33'sd0;
        end
      endcase
    end else begin
      case (cnt_r)
        5'd0, 5'd1, 5'd2: begin
          c_sel = (25'(rt_r[cnt_r[1:0]]) <<< 8) - 25'(bias_r[cnt_r[1:0]]);
          mul_a = 36'(c_sel);
          mul_b = $signed({1'b0, scale_r});
        end
        5'd3: begin
          mul_a = 36'(pitch_r) + 36'(inc_r[1]);
          mul_b = $signed({16'b0, a_eff});
        end
        5'd4: begin
          mul_a = 36'(accp_r);
          mul_b = $signed({16'b0, ALPHA_ONE - a_eff});
        end
        5'd5: begin
          mul_a = 36'(roll_r) + 36'(inc_r[0]);
          mul_b = $signed({16'b0, a_eff});
        end
        5'd6: begin
          mul_a = 36'(accr_r);
          mul_b = $signed({16'b0, ALPHA_ONE - a_eff});
        end
        default: begin
          mul_a = 36'sd0;
          mul_b = 33'sd0;
        end
      endcase
    end
  end

  // remainder of the quotient estimate, below twice the divisor
  logic [31:0] dv_rem;
  assign dv_rem = dvd_r - prod_r[31:0];

  logic signed [24:0] dl_s;
  logic [24:0]        dl_mag;
  assign dl_s   = 25'(sum_r[sel_r]);
  assign dl_mag = dl_s[24] ? 25'(-dl_s) : 25'(dl_s);

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= 5'd0;
      sel_r       <= 2'd0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= (state_nxt != state_r) ? 5'd0 : cnt_r + 5'd1;
      if (state_r == ST_IDLE) sel_r <= 2'd0;
      else if (state_r == ST_CITER && state_nxt == ST_CPRE) sel_r <= 2'd1;
      else if (state_r == ST_DSTORE) sel_r <= sel_r + 2'd1;
      if (out_load)        out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
    end
  end

  // registers, calibration and filter state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alpha_r <= ALPHA_RST;
      scale_r <= SCALE_RST;
      pitch_r <= 32'sd0;
      roll_r  <= 32'sd0;
      yaw_r   <= 32'sd0;
      count_r <= 10'd0;
      for (int k = 0; k < 3; k++) begin
        bias_r[k] <= 24'sd0;
        sum_r[k]  <= 24'sd0;
      end
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_ALPHA: alpha_r <= cfg_data[16:0];
          REG_SCALE: scale_r <= cfg_data;
          default:   ;
        endcase
      end
      if (in_acc && in_command) begin
        count_r <= count_inc;
        if (in_read_ok) begin
          for (int k = 0; k < 3; k++) begin
            logic signed [24:0] t;
            t = 25'(sum_r[k]) + 25'(in_rate[k]);
            if (t > 25'sd8388607)       sum_r[k] <= 24'sh7FFFFF;
            else if (t < -25'sd8388608) sum_r[k] <= 24'sh800000;
            else                        sum_r[k] <= t[23:0];
          end
        end
      end
      if (state_r == ST_MUL) begin
        if (cnt_r == 5'd5) pitch_r <= sat32(rnd_shr(bl_r + prod_r, 16));
        if (cnt_r == 5'd7) begin
          roll_r <= sat32(rnd_shr(bl_r + prod_r, 16));
          yaw_r  <= sat32(69'(yaw_r) + 69'(inc_r[2]));
        end
      end
      if (state_r == ST_DSTORE) begin
        if (dneg_r) bias_r[sel_r] <= (dvd_r > 32'h0080_0000) ? 24'sh800000 : 24'(-dvd_r);
        else        bias_r[sel_r] <= (dvd_r > 32'h007F_FFFF) ? 24'sh7FFFFF : dvd_r[23:0];
        sum_r[sel_r] <= 24'sd0;
        if (sel_r == 2'd2) begin
          count_r <= 10'd0;
          pitch_r <= 32'sd0;
          roll_r  <= 32'sd0;
          yaw_r   <= 32'sd0;
        end
      end
    end
  end

  // datapath (no reset)
  always_ff @(posedge clk) begin
    if (in_acc) begin
      ax_r     <= in_accel_x;
      ay_r     <= in_accel_y;
      az_r     <= in_accel_z;
      rt_r[0]  <= in_rate_x;
      rt_r[1]  <= in_rate_y;
      rt_r[2]  <= in_rate_z;
      n_r      <= {32'(in_accel_y * in_accel_y) + 32'(in_accel_z * in_accel_z), 16'b0};
      rem_r    <= 28'd0;
      root_r   <= 24'd0;
    end
    unique case (state_r)
      ST_SQRT: begin
        n_r <= {n_r[45:0], 2'b00};
        if (sq_t >= sq_trial) begin
          rem_r  <= sq_t - sq_trial;
          root_r <= {root_r[22:0], 1'b1};
        end else begin
          rem_r  <= sq_t;
          root_r <= {root_r[22:0], 1'b0};
        end
      end
      ST_CPRE: begin
        czero_r <= (cx0 == 36'sd0) && (cy0 == 36'sd0);
        if (cx0[35]) begin
          if (!cy0[35]) begin
            cx_r <= cy0;
            cy_r <= -cx0;
            cz_r <= 32'sd5898240;
          end else begin
            cx_r <= -cy0;
            cy_r <= cx0;
            cz_r <= -32'sd5898240;
          end
        end else begin
          cx_r <= cx0;
          cy_r <= cy0;
          cz_r <= 32'sd0;
        end
      end
      ST_CITER: begin
        if (cy_r[35]) begin
          cx_r <= cx_r - cdy;
          cy_r <= cy_r + cdx;
        end else begin
          cx_r <= cx_r + cdy;
          cy_r <= cy_r - cdx;
        end
        cz_r <= cz_upd;
        if (cnt_r == 5'(CORDIC_ITERS - 1)) begin
          if (sel_r == 2'd0) accp_r <= czero_r ? 32'sd0 : cz_upd;
          else               accr_r <= czero_r ? 32'sd0 : cz_upd;
        end
      end
      ST_MUL: begin
        prod_r <= mul_a * mul_b;
        case (cnt_r)
          5'd1:    inc_r[0] <= 35'(rnd_shr(prod_r, 24));
          5'd2:    inc_r[1] <= 35'(rnd_shr(prod_r, 24));
          5'd3:    inc_r[2] <= 35'(rnd_shr(prod_r, 24));
          5'd4:    bl_r     <= prod_r;
          5'd6:    bl_r     <= prod_r;
          default: ;
        endcase
      end
      ST_DLOAD: begin
        dvd_r  <= {dl_mag[23:0], 8'b0} + CAL_HALF;
        dneg_r <= dl_s[24];
      end
      ST_DIV: begin
        prod_r <= mul_a * mul_b;
        if (cnt_r == 5'd1) dq_r <= prod_r[63:32];
        if (cnt_r == 5'd3) dvd_r <= (dv_rem >= CAL_K) ? dq_r + 32'd1 : dq_r;
      end
      default: ;
    endcase
    if (out_load) begin
      out_pitch_r <= pitch_r;
      out_roll_r  <= roll_r;
      out_yaw_r   <= yaw_r;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_pitch_out = out_pitch_r;
  assign out_roll_out  = out_roll_r;
  assign out_yaw_out   = out_yaw_r;

endmodule
`default_nettype wire

/* hw/rtl/ictf_checker.sv */
// Port-level checker for the tilt filter, bound to the top level.
// Depends on imu_complementary_tilt_filter_macros.svh.
`default_nettype none
`include "imu_complementary_tilt_filter_macros.svh"
module ictf_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input logic               in_command,
  input logic               out_valid,
  input logic               out_stall,
  input logic signed [31:0] out_yaw_out
);

  // a taken fuse beat keeps the block busy (in_stall high) in the cycle after it is taken
  `ICTF_ASSERT(a_fuse_busy, in_valid && !in_stall && !in_command |=> in_stall, "fuse beat not held")
  `ICTF_ASSERT_NR(a_reset_idle, !rst_n |=> !out_valid && !in_stall, "not idle after reset")
  `ICTF_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid, "result beat dropped")
  `ICTF_ASSERT(a_out_stable, out_valid && out_stall |=> $stable(out_yaw_out), "stalled beat changed")

endmodule

bind imu_complementary_tilt_filter ictf_checker u_ictf_checker (.*);
`default_nettype wire
